FILE: src/wscp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wscp_pkg
// Shared types, codes and helpers for the close frame payload checker.
// ============================================================================
package wscp_pkg;

    // Verdict codes carried in the result beat
    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_PROTOCOL = 2'd1;
    localparam logic [1:0] VERDICT_REASON   = 2'd2;

    // Close code ranges that are accepted
    localparam logic [15:0] CODE_STD_LO  = 16'd1000;
    localparam logic [15:0] CODE_STD_HI  = 16'd1003;
    localparam logic [15:0] CODE_EXT_LO  = 16'd1007;
    localparam logic [15:0] CODE_EXT_HI  = 16'd1011;
    localparam logic [15:0] CODE_APP_LO  = 16'd3000;
    localparam logic [15:0] CODE_APP_HI  = 16'd4999;

    // UTF-8 limits
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [7:0]  LEAD2_LO     = 8'hC2;
    localparam logic [7:0]  LEAD2_HI     = 8'hDF;
    localparam logic [7:0]  LEAD3_LO     = 8'hE0;
    localparam logic [7:0]  LEAD3_HI     = 8'hEF;
    localparam logic [7:0]  LEAD4_LO     = 8'hF0;
    localparam logic [7:0]  LEAD4_HI     = 8'hF4;
    localparam logic [7:0]  ASCII_MAX    = 8'h7F;
    localparam logic [1:0]  CONT_TAG     = 2'b10;

    // Minimum sequence value classes
    localparam logic [1:0]  MIN_CLASS_2B = 2'd0;
    localparam logic [1:0]  MIN_CLASS_3B = 2'd1;
    localparam logic [1:0]  MIN_CLASS_4B = 2'd2;

    // Where we are in the payload
    typedef enum logic [2:0] {
        POS_NONE = 3'b001,   // no byte seen
        POS_HIGH = 3'b010,   // high code byte seen
        POS_CODE = 3'b100    // code complete, bytes belong to the reason
    } wscp_pos_t;

    // Reason decoder state
    typedef struct packed {
        logic [20:0] codepoint;
        logic [1:0]  remaining;
        logic [1:0]  min_class;
        logic        error;
    } wscp_utf8_t;

    // One result beat
    typedef struct packed {
        logic        code_present;
        logic [15:0] close_code;
        logic [1:0]  verdict;
    } wscp_result_t;

    localparam wscp_utf8_t UTF8_IDLE = '{codepoint: '0, remaining: '0,
                                         min_class: '0, error: 1'b0};

    // Smallest legal value of a sequence of the given class
    function automatic logic [20:0] min_codepoint(input logic [1:0] cls);
        logic [20:0] value;
        case (cls)
            MIN_CLASS_2B: value = 21'h000080;
            MIN_CLASS_3B: value = 21'h000800;
            default:      value = 21'h010000;
        endcase
        return value;
    endfunction

endpackage

FILE: src/websocket_close_payload_check.sv
`timescale 1ns / 1ps
// ============================================================================
// websocket_close_payload_check
// Close frame payload checker: close code range and UTF-8 reason check.
// ============================================================================
// Takes one payload byte per beat, every cycle, with no gaps needed between
// frames. A beat is registered on acceptance and then processed by the
// single-pass byte update; the verdict for a frame is written to the result
// register when its last beat is processed. The only throttle is the result
// register: while a result waits to be taken, the input keeps flowing until
// a further last beat would need that register.
// An empty beat with tlast closes the frame on the bytes seen so far.
module websocket_close_payload_check
    import wscp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    input  logic        s_tuser,     // empty_frame

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata      // [1:0] verdict, [17:2] close_code,
                                     // [18] code_present, [23:19] zero
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         in_empty_reg;

    // payload state
    wscp_pos_t    pos_reg, pos_next;
    logic [15:0]  code_reg, code_next;
    wscp_utf8_t   utf8_reg, utf8_next;

    // result register
    logic         out_valid_reg;
    wscp_result_t out_reg;
    wscp_result_t result;

    logic         advance;
    logic         proc;

    // a beat waiting in the input register can move on unless it is a last beat
    // and the result slot is full and not being drained
    assign advance  = !in_valid_reg || !in_last_reg || !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    // code bytes
    always_comb
    begin
        pos_next  = pos_reg;
        code_next = code_reg;
        if (!in_empty_reg)
        begin
            unique case (pos_reg)
                POS_NONE:
                begin
                    code_next = {in_byte_reg, 8'd0};
                    pos_next  = POS_HIGH;
                end
                POS_HIGH:
                begin
                    code_next = {code_reg[15:8], in_byte_reg};
                    pos_next  = POS_CODE;
                end
                POS_CODE:
                begin
                    pos_next = POS_CODE;
                end
                default:
                begin
                    pos_next = POS_NONE;
                end
            endcase
        end
    end

    // reason bytes
    wscp_utf8 u_utf8 (
        .take      (!in_empty_reg && pos_reg == POS_CODE),
        .data_byte (in_byte_reg),
        .state_in  (utf8_reg),
        .state_out (utf8_next)
    );

    // verdict on the state after this beat
    wscp_verdict u_verdict (
        .pos    (pos_next),
        .code   (code_next),
        .utf8   (utf8_next),
        .result (result)
    );

    // state update; a last beat returns everything to the idle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_NONE;
            code_reg <= 16'd0;
            utf8_reg <= UTF8_IDLE;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                pos_reg  <= POS_NONE;
                code_reg <= 16'd0;
                utf8_reg <= UTF8_IDLE;
            end
            else
            begin
                pos_reg  <= pos_next;
                code_reg <= code_next;
                utf8_reg <= utf8_next;
            end
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.code_present, out_reg.close_code, out_reg.verdict};

    // a finished frame leaves no state behind
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=>
            (pos_reg == POS_NONE && code_reg == 16'd0 &&
             utf8_reg.remaining == 2'd0 && !utf8_reg.error))
        else $error("state not cleared after last beat");

    // a multi-byte sequence can only be open inside the reason
    a_utf8_in_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (utf8_reg.remaining != 2'd0 || utf8_reg.error) |-> (pos_reg == POS_CODE))
        else $error("reason decoder active before the code is complete");

    // an ok verdict with a code carries a valid code
    a_ok_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.verdict == VERDICT_OK && out_reg.code_present) |->
            ((out_reg.close_code >= CODE_STD_LO && out_reg.close_code <= CODE_STD_HI) ||
             (out_reg.close_code >= CODE_EXT_LO && out_reg.close_code <= CODE_EXT_HI) ||
             (out_reg.close_code >= CODE_APP_LO && out_reg.close_code <= CODE_APP_HI)))
        else $error("ok verdict with out-of-range close code");

    // no code means a zero code field and never an invalid reason
    a_absent_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.code_present) |->
            (out_reg.close_code == 16'd0 && out_reg.verdict != VERDICT_REASON))
        else $error("absent code with nonzero code or reason verdict");

    // an unread result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(proc && in_last_reg))
        else $error("result overwritten while stalled");

endmodule

FILE: src/wscp_utf8.sv
`timescale 1ns / 1ps
// ============================================================================
// wscp_utf8
// One-byte update of the UTF-8 reason decoder.
// ============================================================================
module wscp_utf8
    import wscp_pkg::*;
(
    input  logic        take,        // byte belongs to the reason
    input  logic [7:0]  data_byte,
    input  wscp_utf8_t  state_in,
    output wscp_utf8_t  state_out
);

    logic [20:0] cp_shift;
    logic [1:0]  rem_dec;

    assign cp_shift = {state_in.codepoint[14:0], data_byte[5:0]};
    assign rem_dec  = state_in.remaining - 2'd1;

    always_comb
    begin
        state_out = state_in;
        if (take)
        begin
            if (state_in.remaining == 2'd0)
            begin
                // lead byte
                if (data_byte <= ASCII_MAX)
                begin
                    state_out = state_in;
                end
                else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI)
                begin
                    state_out.codepoint = {16'd0, data_byte[4:0]};
                    state_out.remaining = 2'd1;
                    state_out.min_class = MIN_CLASS_2B;
                end
                else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI)
                begin
                    state_out.codepoint = {17'd0, data_byte[3:0]};
                    state_out.remaining = 2'd2;
                    state_out.min_class = MIN_CLASS_3B;
                end
                else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI)
                begin
                    state_out.codepoint = {18'd0, data_byte[2:0]};
                    state_out.remaining = 2'd3;
                    state_out.min_class = MIN_CLASS_4B;
                end
                else
                begin
                    state_out.error = 1'b1;
                end
            end
            else if (data_byte[7:6] != CONT_TAG)
            begin
                // sequence broken off
                state_out.error     = 1'b1;
                state_out.remaining = 2'd0;
            end
            else
            begin
                // continuation byte; check the value once complete
                state_out.codepoint = cp_shift;
                state_out.remaining = rem_dec;
                if (rem_dec == 2'd0)
                begin
                    if (cp_shift < min_codepoint(state_in.min_class) ||
                        cp_shift > CP_MAX ||
                        (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI))
                    begin
                        state_out.error = 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: src/wscp_verdict.sv
`timescale 1ns / 1ps
// ============================================================================
// wscp_verdict
// Forms the result beat from the payload state after the last byte.
// ============================================================================
module wscp_verdict
    import wscp_pkg::*;
(
    input  wscp_pos_t    pos,
    input  logic [15:0]  code,
    input  wscp_utf8_t   utf8,
    output wscp_result_t result
);

    logic code_ok;

    // accepted code ranges
    assign code_ok = (code >= CODE_STD_LO && code <= CODE_STD_HI) ||
                     (code >= CODE_EXT_LO && code <= CODE_EXT_HI) ||
                     (code >= CODE_APP_LO && code <= CODE_APP_HI);

    always_comb
    begin
        result = '{code_present: 1'b0, close_code: 16'd0, verdict: VERDICT_OK};
        unique case (pos)
            POS_NONE:
            begin
                result.verdict = VERDICT_OK;
            end
            POS_HIGH:
            begin
                result.verdict = VERDICT_PROTOCOL;
            end
            POS_CODE:
            begin
                result.code_present = 1'b1;
                result.close_code   = code;
                if (!code_ok)
                    result.verdict = VERDICT_PROTOCOL;
                else if (utf8.error || utf8.remaining != 2'd0)
                    result.verdict = VERDICT_REASON;
                else
                    result.verdict = VERDICT_OK;
            end
            default:
            begin
                result.verdict = VERDICT_PROTOCOL;
            end
        endcase
    end

endmodule

FILE: sim/wscp_close_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wscp_close_checker
// Scoreboard for the close frame payload checker.
// ============================================================================
// Watches both stream channels. Every accepted input beat goes through a
// local model of the close code and UTF-8 reason decoder. A beat with tlast
// queues the verdict that the frame should get. Every accepted result beat
// is compared field by field with the oldest queued verdict.
module wscp_close_checker
    import wscp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    input  logic        s_tuser,     // empty_frame

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,     // [1:0] verdict, [17:2] close_code,
                                     // [18] code_present, [23:19] zero

    output int          mismatches,
    output int          outstanding
);

    // Model state of the frame in progress
    wscp_pos_t    frame_pos;
    logic [15:0]  code_acc;
    wscp_utf8_t   reason_dec;
    wscp_result_t expected_verdicts[$];
    wscp_result_t want;

    function automatic logic close_code_allowed(input logic [15:0] c);
        return (c >= CODE_STD_LO && c <= CODE_STD_HI) ||
               (c >= CODE_EXT_LO && c <= CODE_EXT_HI) ||
               (c >= CODE_APP_LO && c <= CODE_APP_HI);
    endfunction

    task automatic clear_frame();
        frame_pos  = POS_NONE;
        code_acc   = '0;
        reason_dec = '{codepoint: '0, remaining: '0, min_class: '0, error: 1'b0};
    endtask

    // One byte of the reason through the UTF-8 decoder
    task automatic reason_byte(input logic [7:0] b);
        logic [20:0] cp_floor;
        if (reason_dec.remaining == 2'd0)
        begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                reason_dec.codepoint = {16'd0, b[4:0]};
                reason_dec.remaining = 2'd1;
                reason_dec.min_class = MIN_CLASS_2B;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                reason_dec.codepoint = {17'd0, b[3:0]};
                reason_dec.remaining = 2'd2;
                reason_dec.min_class = MIN_CLASS_3B;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                reason_dec.codepoint = {18'd0, b[2:0]};
                reason_dec.remaining = 2'd3;
                reason_dec.min_class = MIN_CLASS_4B;
            end
            else if (b > ASCII_MAX)
            begin
                // stray continuation or a lead byte that can never be legal
                reason_dec.error = 1'b1;
            end
        end
        else if (b[7:6] != CONT_TAG)
        begin
            reason_dec.error     = 1'b1;
            reason_dec.remaining = 2'd0;
        end
        else
        begin
            reason_dec.codepoint = {reason_dec.codepoint[14:0], b[5:0]};
            reason_dec.remaining = reason_dec.remaining - 2'd1;
            if (reason_dec.remaining == 2'd0)
            begin
                case (reason_dec.min_class)
                    MIN_CLASS_2B: cp_floor = 21'h000080;
                    MIN_CLASS_3B: cp_floor = 21'h000800;
                    default:      cp_floor = 21'h010000;
                endcase
                // overlong, beyond the code space, or a surrogate
                if (reason_dec.codepoint < cp_floor || reason_dec.codepoint > CP_MAX ||
                    (reason_dec.codepoint >= CP_SURR_LO &&
                     reason_dec.codepoint <= CP_SURR_HI))
                    reason_dec.error = 1'b1;
            end
        end
    endtask

    // Advance the model by one accepted beat; queue a verdict on tlast
    task automatic predict_close_beat(input logic [7:0] d, input logic l, input logic e);
        wscp_result_t r;
        if (!e)
        begin
            case (frame_pos)
                POS_NONE:
                begin
                    code_acc  = {d, 8'h00};
                    frame_pos = POS_HIGH;
                end
                POS_HIGH:
                begin
                    code_acc[7:0] = d;
                    frame_pos     = POS_CODE;
                end
                default: reason_byte(d);
            endcase
        end
        if (l)
        begin
            case (frame_pos)
                POS_NONE: r = '{code_present: 1'b0, close_code: '0, verdict: VERDICT_OK};
                POS_HIGH: r = '{code_present: 1'b0, close_code: '0, verdict: VERDICT_PROTOCOL};
                default:
                begin
                    r.code_present = 1'b1;
                    r.close_code   = code_acc;
                    if (!close_code_allowed(code_acc))
                        r.verdict = VERDICT_PROTOCOL;
                    else if (reason_dec.error || reason_dec.remaining != 2'd0)
                        r.verdict = VERDICT_REASON;
                    else
                        r.verdict = VERDICT_OK;
                end
            endcase
            expected_verdicts.push_back(r);
            clear_frame();
        end
    endtask

    // Results are checked before the same edge's input is modeled, so a
    // result can never be matched against a frame closed at that very edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_verdicts.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result beat 0x%06h with no closed frame waiting", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[1:0] !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_tdata[17:2] !== want.close_code)
                    begin
                        $error("close_code: expected %0d, got %0d",
                               want.close_code, m_tdata[17:2]);
                        mismatches++;
                    end
                    if (m_tdata[18] !== want.code_present)
                    begin
                        $error("code_present: expected %0d, got %0d",
                               want.code_present, m_tdata[18]);
                        mismatches++;
                    end
                    if (m_tdata[23:19] !== 5'd0)
                    begin
                        $error("pad: expected 0, got 0x%02h", m_tdata[23:19]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_close_beat(s_tdata, s_tlast, s_tuser);
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

FILE: sim/tb_websocket_close_payload_check.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_websocket_close_payload_check
// Stimulus and verdict for the close frame payload checker.
// ============================================================================
// A few hand-built frames hit the code range edges, the special empty beats,
// a surrogate, the top of the code space and a cut-off sequence. Then random
// frames follow, most often a legal code with well-formed UTF-8, the rest with
// broken sequences, bad codes or raw noise. The sender runs in bursts, the
// receiver stalls in changing patterns, and the scoreboard checks every
// result beat.
module tb_websocket_close_payload_check;

    localparam int BEAT_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [15:0] EDGE_CODES [0:7] = '{16'd999, 16'd1004, 16'd1006, 16'd1012,
                                                  16'd2999, 16'd5000, 16'd0, 16'd65535};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;    // last_byte
    logic        s_tuser  = 1'b0;    // empty_frame
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [1:0] verdict, [17:2] close_code,
                                     // [18] code_present, [23:19] zero
    int          mismatches;
    int          outstanding;

    logic [7:0]  frame_bytes[$];
    int          burst_left = 0;
    int          beats_sent = 0;

    websocket_close_payload_check u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wscp_close_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Receiver: always ready, coin-flip ready, or ready with long stalls
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom % 3;
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom % 2);
                default:
                begin
                    if ($urandom % 8 == 0)
                    begin
                        stall_left = $urandom_range(1, 24);
                        m_tready <= 1'b0;
                    end
                    else
                        m_tready <= 1'b1;
                end
            endcase
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("websocket_close_payload_check: mismatch");
        $finish;
    end

    // One input beat, with a random gap at the start of each burst
    task automatic send_beat(input logic [7:0] d, input logic l, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        s_tuser  <= e;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Hold the input off until every queued verdict has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Send frame_bytes as one payload; optionally close it with an empty
    // tlast beat and sprinkle ignored empty beats in between
    task automatic send_frame(input bit close_empty, input bit noise);
        int n;
        n = frame_bytes.size();
        if (n == 0)
        begin
            send_beat(8'($urandom), 1'b1, 1'b1);
            beats_sent++;
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (noise && $urandom % 25 == 0)
                    send_beat(8'($urandom), 1'b0, 1'b1);
                send_beat(frame_bytes[i], (i == n - 1) && !close_empty, 1'b0);
                beats_sent++;
            end
            if (close_empty)
            begin
                send_beat(8'($urandom), 1'b1, 1'b1);
                beats_sent++;
            end
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom % 64);
    endfunction

    function automatic logic [15:0] pick_close_code(input bit allowed);
        logic [15:0] c;
        if (allowed)
        begin
            case ($urandom % 4)
                0:       c = 16'($urandom_range(1000, 1003));
                1:       c = 16'($urandom_range(1007, 1011));
                2:       c = ($urandom % 2) ? 16'd3000 : 16'd4999;
                default: c = 16'($urandom_range(3000, 4999));
            endcase
        end
        else if ($urandom % 3 == 0)
            c = 16'($urandom);
        else
            c = EDGE_CODES[$urandom % 8];
        return c;
    endfunction

    // Append one character; kinds 0..3 are legal 1..4 byte forms, 4 is bad
    task automatic add_char(input int kind);
        logic [20:0] cp;
        bit          edge_pick;
        edge_pick = ($urandom % 4 == 0);
        case (kind)
            0:
            begin
                cp = edge_pick ? (($urandom % 2) ? 21'h7F : 21'h00)
                               : 21'($urandom_range(0, 127));
                frame_bytes.push_back(cp[7:0]);
            end
            1:
            begin
                cp = edge_pick ? (($urandom % 2) ? 21'h7FF : 21'h80)
                               : 21'($urandom_range(21'h80, 21'h7FF));
                frame_bytes.push_back({3'b110, cp[10:6]});
                frame_bytes.push_back({2'b10, cp[5:0]});
            end
            2:
            begin
                cp = edge_pick ? (($urandom % 2) ? 21'hFFFF : 21'h800)
                               : 21'($urandom_range(21'h800, 21'hFFFF));
                // move surrogates up out of the surrogate block
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h2000;
                frame_bytes.push_back({4'b1110, cp[15:12]});
                frame_bytes.push_back({2'b10, cp[11:6]});
                frame_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                cp = edge_pick ? (($urandom % 2) ? 21'h10FFFF : 21'h10000)
                               : 21'($urandom_range(21'h10000, 21'h10FFFF));
                frame_bytes.push_back({5'b11110, cp[20:18]});
                frame_bytes.push_back({2'b10, cp[17:12]});
                frame_bytes.push_back({2'b10, cp[11:6]});
                frame_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                case ($urandom % 6)
                    0:
                    begin
                        // two byte overlong
                        frame_bytes.push_back(8'hC0 | 8'($urandom % 2));
                        frame_bytes.push_back(cont_byte());
                    end
                    1:
                    begin
                        // three byte overlong
                        frame_bytes.push_back(8'hE0);
                        frame_bytes.push_back(8'h80 | 8'($urandom % 32));
                        frame_bytes.push_back(cont_byte());
                    end
                    2:
                    begin
                        // four byte overlong
                        frame_bytes.push_back(8'hF0);
                        frame_bytes.push_back(8'h80 | 8'($urandom % 16));
                        frame_bytes.push_back(cont_byte());
                        frame_bytes.push_back(cont_byte());
                    end
                    3:
                    begin
                        // surrogate
                        frame_bytes.push_back(8'hED);
                        frame_bytes.push_back(8'hA0 | 8'($urandom % 32));
                        frame_bytes.push_back(cont_byte());
                    end
                    4:
                    begin
                        // above the top of the code space
                        frame_bytes.push_back(8'hF4);
                        frame_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                        frame_bytes.push_back(cont_byte());
                        frame_bytes.push_back(cont_byte());
                    end
                    default:
                    begin
                        // stray continuation or an impossible lead
                        if ($urandom % 2)
                            frame_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        else
                            frame_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                    end
                endcase
            end
        endcase
    endtask

    // Fill frame_bytes with one random payload
    task automatic build_random_frame(output bit close_empty);
        int          r;
        int          nchars;
        int          bad_at;
        logic [15:0] code;
        r = $urandom % 100;
        frame_bytes.delete();
        nchars = ($urandom % 5 == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
        if (r < 8)
        begin
            // empty payload
        end
        else if (r < 14)
            frame_bytes.push_back(8'($urandom));
        else if (r < 80)
        begin
            code = pick_close_code(1'b1);
            frame_bytes.push_back(code[15:8]);
            frame_bytes.push_back(code[7:0]);
            bad_at = (r >= 55 && r < 70) ? $urandom_range(0, nchars) : -1;
            for (int i = 0; i <= nchars; i++)
            begin
                if (i == bad_at)
                    add_char(4);
                else if (i < nchars)
                    add_char($urandom % 4);
            end
            // cut the final multi-byte character short
            if (r >= 70)
            begin
                add_char($urandom_range(1, 3));
                void'(frame_bytes.pop_back());
            end
        end
        else
        begin
            code = pick_close_code(1'($urandom % 2));
            frame_bytes.push_back(code[15:8]);
            frame_bytes.push_back(code[7:0]);
            for (int i = 0; i < nchars; i++)
            begin
                if ($urandom % 2)
                    frame_bytes.push_back(8'($urandom));
                else
                    add_char($urandom % 5);
            end
        end
        close_empty = (frame_bytes.size() != 0) && ($urandom % 6 == 0);
    endtask

    initial
    begin
        bit close_empty;
        int frame_count;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        frame_bytes.delete();
        send_frame(1'b0, 1'b0);                          // empty payload: ok
        frame_bytes = {8'h03};
        send_frame(1'b1, 1'b0);                          // one byte, closed empty
        send_beat(8'h5A, 1'b0, 1'b1);                    // ignored empty beat
        frame_bytes = {8'h03, 8'hE8};
        send_frame(1'b0, 1'b0);                          // 1000, no reason
        frame_bytes = {8'h13, 8'h87, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_frame(1'b0, 1'b0);                          // 4999, top code point
        frame_bytes = {8'h03, 8'hF3, 8'h00, 8'hED, 8'hA0, 8'h80};
        send_frame(1'b0, 1'b0);                          // 1011, surrogate
        frame_bytes = {8'h13, 8'h88, 8'hFF};
        send_frame(1'b0, 1'b0);                          // bad code beats bad reason
        frame_bytes = {8'h03, 8'hEF, 8'hE2, 8'h82};
        send_frame(1'b0, 1'b0);                          // 1007, cut-off sequence

        drain_results();

        // Random frames
        frame_count = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            build_random_frame(close_empty);
            send_frame(close_empty, 1'b1);
            frame_count++;
            if (frame_count % 60 == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("websocket_close_payload_check: match");
        else
            $display("websocket_close_payload_check: mismatch");
        $finish;
    end

endmodule
